// ----- src/process_state_list_engine_defines.svh -----
// Assertion macros used by the process state list engine sequencer (psle_seq).
`ifndef PROCESS_STATE_LIST_ENGINE_DEFINES_SVH
`define PROCESS_STATE_LIST_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
`define PSLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define PSLE_ASSERT_NEVER(lbl, cond, msg) \
    `PSLE_ASSERT(lbl, !(cond), msg)
`else
`define PSLE_ASSERT(lbl, prop, msg)
`define PSLE_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- src/psle_pkg.sv -----
// Types and codes of the process state list engine.
`default_nettype none
package psle_pkg;

    localparam int NSTATES = 6;

    typedef enum logic [2:0] {
        PS_UNUSED,
        PS_EMBRYO,
        PS_SLEEPING,
        PS_RUNNABLE,
        PS_RUNNING,
        PS_ZOMBIE
    } pstate_t;

    typedef enum logic [3:0] {
        ACT_ALLOC,
        ACT_START,
        ACT_FREE,
        ACT_SCHED,
        ACT_YIELD,
        ACT_SLEEP,
        ACT_WAKE,
        ACT_EXIT,
        ACT_WAIT,
        ACT_KILL
    } action_t;

    typedef enum logic [2:0] {
        STS_OK,
        STS_EMPTY,
        STS_WRONG_STATE,
        STS_NO_CHILDREN,
        STS_CHILDREN_ALIVE,
        STS_NOT_FOUND,
        STS_CALLER_KILLED
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SCHED,
        S_SCAN,
        S_EX_SCAN,
        S_EX_AFTER,
        S_EX_RD,
        S_EX_MV,
        S_WT_LOOP,
        S_WT_CHK,
        S_WK_LOOP,
        S_WK_CHK,
        S_MV_WALK,
        S_MV_HOP,
        S_MV_CUT,
        S_MV_PUSH,
        S_MV_LINK,
        S_FINISH
    } seq_state_t;

    typedef enum logic [1:0] {
        SCAN_EXIT,
        SCAN_WAIT,
        SCAN_KILL
    } scan_mode_t;

    typedef struct packed {
        logic [31:0] target_pid;
        logic [31:0] chan;
        logic [5:0]  parent_slot;
        logic        has_parent;
        logic [5:0]  slot;
        logic [3:0]  action;
    } req_t;

    typedef struct packed {
        logic [6:0]  woken_count;
        logic [31:0] pid_out;
        logic [5:0]  slot_out;
        status_t     status;
    } res_t;

    typedef struct packed {
        logic rec_re;
        logic rec_we;
        logic lnk_re;
        logic lnk_we;
    } tbl_ctl_t;

endpackage
`default_nettype wire

// ----- src/process_state_list_engine.sv -----
// Top level of the process state list engine: stream ports, output register, table.
// Simple actions read the entry, walk its current list up to it, then unlink it and append it to the new list.
// Wakeup, exit, wait and kill walk or scan the table: the sleeping list is walked entry by entry,
// each woken entry is moved to the runnable list, and scans read every table entry in turn.
// One transaction at a time; the record and link memories each have one read port and one write port.
// Reset: synchronous; then a sweep over all ENTRIES slots initializes the memories, s_tready low.
`default_nettype none
module process_state_list_engine #(
    parameter int ENTRIES = 64,
    parameter int CHAN_BITS = 32,
    parameter int PID_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic [5:0]  cfg_wdata,   // init_slot
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,     // action, slot, has_parent, parent_slot, chan, target_pid
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata      // status, slot_out, pid_out, woken_count
);
    import psle_pkg::*;

    localparam int EW = $clog2(ENTRIES);
    localparam int PW = $clog2(ENTRIES + 1);
    localparam int RW = 4 + CHAN_BITS + PW + PID_BITS;

    tbl_ctl_t ctl;
    logic [EW-1:0] rec_raddr, rec_waddr, lnk_raddr, lnk_waddr;
    logic [RW-1:0] rec_wdata, rec_rdata;
    logic [PW-1:0] lnk_wdata, lnk_rdata;
    logic seq_ready, done_valid, done_ready;
    req_t req;
    res_t res;
    logic out_valid_reg, out_valid_next;
    res_t out_data_reg, out_data_next;

    assign req = req_t'(s_tdata[80:0]);
    assign s_tready = seq_ready;
    assign done_ready = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        if (done_valid && done_ready) begin
            out_valid_next = 1'b1;
            out_data_next = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    psle_table #(
        .ENTRIES (ENTRIES),
        .RW      (RW)
    ) u_table (
        .aclk      (aclk),
        .ctl       (ctl),
        .rec_raddr (rec_raddr),
        .rec_waddr (rec_waddr),
        .rec_wdata (rec_wdata),
        .rec_rdata (rec_rdata),
        .lnk_raddr (lnk_raddr),
        .lnk_waddr (lnk_waddr),
        .lnk_wdata (lnk_wdata),
        .lnk_rdata (lnk_rdata)
    );

    psle_seq #(
        .ENTRIES   (ENTRIES),
        .CHAN_BITS (CHAN_BITS),
        .PID_BITS  (PID_BITS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .start      (s_tvalid),
        .req        (req),
        .ready      (seq_ready),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .res        (res),
        .ctl        (ctl),
        .rec_raddr  (rec_raddr),
        .rec_waddr  (rec_waddr),
        .rec_wdata  (rec_wdata),
        .rec_rdata  (rec_rdata),
        .lnk_raddr  (lnk_raddr),
        .lnk_waddr  (lnk_waddr),
        .lnk_wdata  (lnk_wdata),
        .lnk_rdata  (lnk_rdata)
    );

endmodule
`default_nettype wire

// ----- src/psle_table.sv -----
// Entry record memory and list link memory with registered reads.
`default_nettype none
module psle_table #(
    parameter int ENTRIES = 64,
    parameter int RW = 82,
    localparam int EW = $clog2(ENTRIES),
    localparam int PW = $clog2(ENTRIES + 1)
) (
    input  wire logic                aclk,
    input  wire psle_pkg::tbl_ctl_t  ctl,
    input  wire logic [EW-1:0]       rec_raddr,
    input  wire logic [EW-1:0]       rec_waddr,
    input  wire logic [RW-1:0]       rec_wdata,
    output logic      [RW-1:0]       rec_rdata,
    input  wire logic [EW-1:0]       lnk_raddr,
    input  wire logic [EW-1:0]       lnk_waddr,
    input  wire logic [PW-1:0]       lnk_wdata,
    output logic      [PW-1:0]       lnk_rdata
);
    import psle_pkg::*;

    logic [RW-1:0] rec_mem [ENTRIES];
    logic [PW-1:0] lnk_mem [ENTRIES];

    always_ff @(posedge aclk) begin
        if (ctl.rec_we) begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        if (ctl.rec_re) begin
            rec_rdata <= rec_mem[rec_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.lnk_we) begin
            lnk_mem[lnk_waddr] <= lnk_wdata;
        end
        if (ctl.lnk_re) begin
            lnk_rdata <= lnk_mem[lnk_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- src/psle_seq.sv -----
// Action sequencer: list walks, table scans and list moves over the entry table.
`default_nettype none
`include "process_state_list_engine_defines.svh"
module psle_seq #(
    parameter int ENTRIES = 64,
    parameter int CHAN_BITS = 32,
    parameter int PID_BITS = 32,
    localparam int EW = $clog2(ENTRIES),
    localparam int PW = $clog2(ENTRIES + 1),
    localparam int RW = 4 + CHAN_BITS + PW + PID_BITS
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wen,
    input  wire logic [5:0]          cfg_wdata,
    input  wire logic                start,
    input  wire psle_pkg::req_t      req,
    output logic                     ready,
    output logic                     done_valid,
    input  wire logic                done_ready,
    output psle_pkg::res_t           res,
    output psle_pkg::tbl_ctl_t       ctl,
    output logic      [EW-1:0]       rec_raddr,
    output logic      [EW-1:0]       rec_waddr,
    output logic      [RW-1:0]       rec_wdata,
    input  wire logic [RW-1:0]       rec_rdata,
    output logic      [EW-1:0]       lnk_raddr,
    output logic      [EW-1:0]       lnk_waddr,
    output logic      [PW-1:0]       lnk_wdata,
    input  wire logic [PW-1:0]       lnk_rdata
);
    import psle_pkg::*;

    typedef struct packed {
        logic                 killed;
        logic [CHAN_BITS-1:0] chan;
        logic [PW-1:0]        parent;
        logic [PID_BITS-1:0]  pid;
        pstate_t              state;
    } rec_t;

    localparam logic [PW-1:0] NIL = PW'(ENTRIES);
    localparam logic [EW-1:0] LAST = EW'(ENTRIES - 1);

    seq_state_t fsm_reg, fsm_next;
    seq_state_t mv_ret_reg, mv_ret_next;
    seq_state_t wk_ret_reg, wk_ret_next;
    req_t req_reg, req_next;
    logic [5:0] init_reg;
    rec_t srec_reg, srec_next;
    rec_t rec_reg, rec_next;
    res_t res_reg, res_next;
    logic [PID_BITS-1:0] next_pid_reg, next_pid_next;
    logic [PW-1:0] head_reg [NSTATES];
    logic [PW-1:0] head_next [NSTATES];
    logic [PW-1:0] tail_reg [NSTATES];
    logic [PW-1:0] tail_next [NSTATES];
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] prev_reg, prev_next;
    logic [PW-1:0] wk_cur_reg, wk_cur_next;
    logic [EW-1:0] mv_e_reg, mv_e_next;
    pstate_t mv_s_reg, mv_s_next;
    pstate_t mv_ns_reg, mv_ns_next;
    logic [CHAN_BITS-1:0] tok_reg, tok_next;
    logic [PW-1:0] scan_idx_reg, scan_idx_next;
    logic chk_vld_reg, chk_vld_next;
    logic [EW-1:0] chk_idx_reg, chk_idx_next;
    scan_mode_t mode_reg, mode_next;
    logic zp_reg, zp_next;
    logic [EW-1:0] clr_idx_reg, clr_idx_next;

    rec_t rd_rec;
    rec_t wr_rec;
    logic slot_ok;
    logic pslot_ok;
    logic adopter;
    logic [PW-1:0] slot_p;
    logic [EW-1:0] slot_e;
    logic [PW-1:0] init_p;
    logic stop;

    assign rd_rec = rec_t'(rec_rdata);
    assign rec_wdata = RW'(wr_rec);
    assign slot_ok = {26'd0, req_reg.slot} < 32'(ENTRIES);
    assign pslot_ok = {26'd0, req_reg.parent_slot} < 32'(ENTRIES);
    assign adopter = {26'd0, init_reg} < 32'(ENTRIES);
    assign slot_p = PW'(req_reg.slot);
    assign slot_e = EW'(req_reg.slot);
    assign init_p = PW'(init_reg);
    assign ready = (fsm_reg == S_IDLE);
    assign done_valid = (fsm_reg == S_FINISH);
    assign res = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg <= S_CLEAR;
            init_reg <= '0;
            next_pid_reg <= PID_BITS'(1);
            clr_idx_reg <= '0;
            chk_vld_reg <= 1'b0;
            for (int i = 0; i < NSTATES; i++) begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
            head_reg[PS_UNUSED] <= '0;
            tail_reg[PS_UNUSED] <= PW'(ENTRIES - 1);
        end else begin
            fsm_reg <= fsm_next;
            if (cfg_wen) begin
                init_reg <= cfg_wdata;
            end
            next_pid_reg <= next_pid_next;
            clr_idx_reg <= clr_idx_next;
            chk_vld_reg <= chk_vld_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        mv_ret_reg <= mv_ret_next;
        wk_ret_reg <= wk_ret_next;
        req_reg <= req_next;
        srec_reg <= srec_next;
        rec_reg <= rec_next;
        res_reg <= res_next;
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        wk_cur_reg <= wk_cur_next;
        mv_e_reg <= mv_e_next;
        mv_s_reg <= mv_s_next;
        mv_ns_reg <= mv_ns_next;
        tok_reg <= tok_next;
        scan_idx_reg <= scan_idx_next;
        chk_idx_reg <= chk_idx_next;
        mode_reg <= mode_next;
        zp_reg <= zp_next;
    end

    always_comb begin
        fsm_next = fsm_reg;
        mv_ret_next = mv_ret_reg;
        wk_ret_next = wk_ret_reg;
        req_next = req_reg;
        srec_next = srec_reg;
        rec_next = rec_reg;
        res_next = res_reg;
        next_pid_next = next_pid_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        wk_cur_next = wk_cur_reg;
        mv_e_next = mv_e_reg;
        mv_s_next = mv_s_reg;
        mv_ns_next = mv_ns_reg;
        tok_next = tok_reg;
        scan_idx_next = scan_idx_reg;
        chk_vld_next = chk_vld_reg;
        chk_idx_next = chk_idx_reg;
        mode_next = mode_reg;
        zp_next = zp_reg;
        clr_idx_next = clr_idx_reg;
        ctl = '0;
        rec_raddr = '0;
        rec_waddr = '0;
        wr_rec = rec_reg;
        lnk_raddr = '0;
        lnk_waddr = '0;
        lnk_wdata = '0;
        stop = 1'b0;

        case (fsm_reg)
            S_CLEAR: begin
                ctl.rec_we = 1'b1;
                ctl.lnk_we = 1'b1;
                rec_waddr = clr_idx_reg;
                lnk_waddr = clr_idx_reg;
                wr_rec = '0;
                wr_rec.parent = NIL;
                wr_rec.state = PS_UNUSED;
                lnk_wdata = PW'(clr_idx_reg) + PW'(1);
                clr_idx_next = clr_idx_reg + EW'(1);
                if (clr_idx_reg == LAST) begin
                    fsm_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    req_next = req;
                    ctl.rec_re = 1'b1;
                    rec_raddr = EW'(req.slot);
                    fsm_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                srec_next = rd_rec;
                res_next = '0;
                res_next.status = STS_OK;
                mv_ret_next = S_FINISH;
                wk_ret_next = S_FINISH;
                prev_next = NIL;
                fsm_next = S_FINISH;
                case (req_reg.action)
                    ACT_ALLOC: begin
                        if (head_reg[PS_UNUSED] == NIL) begin
                            res_next.status = STS_EMPTY;
                        end else begin
                            rec_next = '0;
                            rec_next.parent = NIL;
                            rec_next.pid = next_pid_reg;
                            rec_next.state = PS_EMBRYO;
                            res_next.slot_out = 6'(head_reg[PS_UNUSED]);
                            res_next.pid_out = 32'(next_pid_reg);
                            next_pid_next = next_pid_reg + PID_BITS'(1);
                            mv_e_next = EW'(head_reg[PS_UNUSED]);
                            mv_s_next = PS_UNUSED;
                            mv_ns_next = PS_EMBRYO;
                            cur_next = head_reg[PS_UNUSED];
                            fsm_next = S_MV_WALK;
                        end
                    end
                    ACT_START, ACT_FREE: begin
                        if (!slot_ok || rd_rec.state != PS_EMBRYO) begin
                            res_next.status = STS_WRONG_STATE;
                        end else begin
                            rec_next = rd_rec;
                            mv_e_next = slot_e;
                            mv_s_next = PS_EMBRYO;
                            cur_next = head_reg[PS_EMBRYO];
                            fsm_next = S_MV_WALK;
                            if (req_reg.action == ACT_START) begin
                                rec_next.parent = (req_reg.has_parent && pslot_ok) ?
                                    PW'(req_reg.parent_slot) : NIL;
                                mv_ns_next = PS_RUNNABLE;
                            end else begin
                                rec_next.parent = NIL;
                                rec_next.killed = 1'b0;
                                rec_next.chan = '0;
                                mv_ns_next = PS_UNUSED;
                            end
                        end
                    end
                    ACT_SCHED: begin
                        if (head_reg[PS_RUNNABLE] == NIL) begin
                            res_next.status = STS_EMPTY;
                        end else begin
                            ctl.rec_re = 1'b1;
                            rec_raddr = EW'(head_reg[PS_RUNNABLE]);
                            fsm_next = S_SCHED;
                        end
                    end
                    ACT_YIELD, ACT_SLEEP: begin
                        if (!slot_ok || rd_rec.state != PS_RUNNING) begin
                            res_next.status = STS_WRONG_STATE;
                        end else begin
                            rec_next = rd_rec;
                            mv_e_next = slot_e;
                            mv_s_next = PS_RUNNING;
                            cur_next = head_reg[PS_RUNNING];
                            fsm_next = S_MV_WALK;
                            if (req_reg.action == ACT_SLEEP) begin
                                rec_next.chan = CHAN_BITS'(req_reg.chan);
                                mv_ns_next = PS_SLEEPING;
                            end else begin
                                mv_ns_next = PS_RUNNABLE;
                            end
                        end
                    end
                    ACT_WAKE: begin
                        tok_next = CHAN_BITS'(req_reg.chan);
                        wk_cur_next = head_reg[PS_SLEEPING];
                        fsm_next = S_WK_LOOP;
                    end
                    ACT_EXIT: begin
                        if (!slot_ok || rd_rec.state != PS_RUNNING ||
                            req_reg.slot == init_reg) begin
                            res_next.status = STS_WRONG_STATE;
                        end else if (rd_rec.parent != NIL) begin
                            tok_next = CHAN_BITS'(rd_rec.parent);
                            wk_cur_next = head_reg[PS_SLEEPING];
                            wk_ret_next = S_EX_SCAN;
                            fsm_next = S_WK_LOOP;
                        end else begin
                            fsm_next = S_EX_SCAN;
                        end
                    end
                    ACT_WAIT: begin
                        if (!slot_ok || rd_rec.state != PS_RUNNING) begin
                            res_next.status = STS_WRONG_STATE;
                        end else begin
                            cur_next = head_reg[PS_ZOMBIE];
                            fsm_next = S_WT_LOOP;
                        end
                    end
                    ACT_KILL: begin
                        res_next.status = STS_NOT_FOUND;
                        mode_next = SCAN_KILL;
                        scan_idx_next = '0;
                        chk_vld_next = 1'b0;
                        fsm_next = S_SCAN;
                    end
                    default: begin
                        res_next.status = STS_WRONG_STATE;
                    end
                endcase
            end
            S_SCHED: begin
                rec_next = rd_rec;
                res_next.slot_out = 6'(head_reg[PS_RUNNABLE]);
                res_next.pid_out = 32'(rd_rec.pid);
                mv_e_next = EW'(head_reg[PS_RUNNABLE]);
                mv_s_next = PS_RUNNABLE;
                mv_ns_next = PS_RUNNING;
                cur_next = head_reg[PS_RUNNABLE];
                fsm_next = S_MV_WALK;
            end
            S_EX_SCAN: begin
                mode_next = SCAN_EXIT;
                scan_idx_next = '0;
                chk_vld_next = 1'b0;
                zp_next = 1'b0;
                fsm_next = S_SCAN;
            end
            S_SCAN: begin
                if (chk_vld_reg) begin
                    case (mode_reg)
                        SCAN_EXIT: begin
                            if (rd_rec.parent == slot_p) begin
                                ctl.rec_we = 1'b1;
                                rec_waddr = chk_idx_reg;
                                wr_rec = rd_rec;
                                wr_rec.parent = adopter ? init_p : NIL;
                                if (rd_rec.state == PS_ZOMBIE) begin
                                    zp_next = 1'b1;
                                end
                            end
                        end
                        SCAN_WAIT: begin
                            if (rd_rec.parent == slot_p) begin
                                stop = 1'b1;
                                res_next.status = srec_reg.killed ?
                                    STS_CALLER_KILLED : STS_CHILDREN_ALIVE;
                                fsm_next = S_FINISH;
                            end
                        end
                        SCAN_KILL: begin
                            if (rd_rec.state inside {PS_EMBRYO, PS_SLEEPING,
                                                     PS_RUNNABLE, PS_RUNNING} &&
                                rd_rec.pid == PID_BITS'(req_reg.target_pid)) begin
                                stop = 1'b1;
                                res_next.status = STS_OK;
                                rec_next = rd_rec;
                                rec_next.killed = 1'b1;
                                if (rd_rec.state == PS_SLEEPING) begin
                                    rec_next.chan = '0;
                                    res_next.woken_count = 7'd1;
                                    mv_e_next = chk_idx_reg;
                                    mv_s_next = PS_SLEEPING;
                                    mv_ns_next = PS_RUNNABLE;
                                    cur_next = head_reg[PS_SLEEPING];
                                    prev_next = NIL;
                                    mv_ret_next = S_FINISH;
                                    fsm_next = S_MV_WALK;
                                end else begin
                                    ctl.rec_we = 1'b1;
                                    rec_waddr = chk_idx_reg;
                                    wr_rec = rd_rec;
                                    wr_rec.killed = 1'b1;
                                    fsm_next = S_FINISH;
                                end
                            end
                        end
                        default: begin
                            stop = 1'b1;
                            fsm_next = S_FINISH;
                        end
                    endcase
                end
                if (stop) begin
                    chk_vld_next = 1'b0;
                end else if (scan_idx_reg != NIL) begin
                    ctl.rec_re = 1'b1;
                    rec_raddr = EW'(scan_idx_reg);
                    chk_vld_next = 1'b1;
                    chk_idx_next = EW'(scan_idx_reg);
                    scan_idx_next = scan_idx_reg + PW'(1);
                end else begin
                    chk_vld_next = 1'b0;
                    if (!chk_vld_reg) begin
                        case (mode_reg)
                            SCAN_EXIT: fsm_next = S_EX_AFTER;
                            SCAN_WAIT: begin
                                res_next.status = STS_NO_CHILDREN;
                                fsm_next = S_FINISH;
                            end
                            default: fsm_next = S_FINISH;
                        endcase
                    end
                end
            end
            S_EX_AFTER: begin
                if (zp_reg && adopter) begin
                    tok_next = CHAN_BITS'(init_p);
                    wk_cur_next = head_reg[PS_SLEEPING];
                    prev_next = NIL;
                    wk_ret_next = S_EX_RD;
                    fsm_next = S_WK_LOOP;
                end else begin
                    fsm_next = S_EX_RD;
                end
            end
            S_EX_RD: begin
                ctl.rec_re = 1'b1;
                rec_raddr = slot_e;
                fsm_next = S_EX_MV;
            end
            S_EX_MV: begin
                rec_next = rd_rec;
                mv_e_next = slot_e;
                mv_s_next = PS_RUNNING;
                mv_ns_next = PS_ZOMBIE;
                cur_next = head_reg[PS_RUNNING];
                prev_next = NIL;
                mv_ret_next = S_FINISH;
                fsm_next = S_MV_WALK;
            end
            S_WT_LOOP: begin
                if (cur_reg == NIL) begin
                    mode_next = SCAN_WAIT;
                    scan_idx_next = '0;
                    chk_vld_next = 1'b0;
                    fsm_next = S_SCAN;
                end else begin
                    ctl.rec_re = 1'b1;
                    ctl.lnk_re = 1'b1;
                    rec_raddr = EW'(cur_reg);
                    lnk_raddr = EW'(cur_reg);
                    fsm_next = S_WT_CHK;
                end
            end
            S_WT_CHK: begin
                if (rd_rec.parent == slot_p) begin
                    res_next.slot_out = 6'(cur_reg);
                    res_next.pid_out = 32'(rd_rec.pid);
                    rec_next = '0;
                    rec_next.parent = NIL;
                    rec_next.state = PS_ZOMBIE;
                    mv_e_next = EW'(cur_reg);
                    mv_s_next = PS_ZOMBIE;
                    mv_ns_next = PS_UNUSED;
                    cur_next = head_reg[PS_ZOMBIE];
                    prev_next = NIL;
                    mv_ret_next = S_FINISH;
                    fsm_next = S_MV_WALK;
                end else begin
                    cur_next = lnk_rdata;
                    fsm_next = S_WT_LOOP;
                end
            end
            S_WK_LOOP: begin
                if (wk_cur_reg == NIL) begin
                    fsm_next = wk_ret_reg;
                end else begin
                    ctl.rec_re = 1'b1;
                    ctl.lnk_re = 1'b1;
                    rec_raddr = EW'(wk_cur_reg);
                    lnk_raddr = EW'(wk_cur_reg);
                    fsm_next = S_WK_CHK;
                end
            end
            S_WK_CHK: begin
                wk_cur_next = lnk_rdata;
                if (rd_rec.chan == tok_reg) begin
                    rec_next = rd_rec;
                    rec_next.chan = '0;
                    mv_e_next = EW'(wk_cur_reg);
                    mv_s_next = PS_SLEEPING;
                    mv_ns_next = PS_RUNNABLE;
                    mv_ret_next = S_WK_LOOP;
                    res_next.woken_count = res_reg.woken_count + 7'd1;
                    fsm_next = S_MV_CUT;
                end else begin
                    prev_next = wk_cur_reg;
                    fsm_next = S_WK_LOOP;
                end
            end
            S_MV_WALK: begin
                if (cur_reg == PW'(mv_e_reg)) begin
                    ctl.lnk_re = 1'b1;
                    lnk_raddr = mv_e_reg;
                    fsm_next = S_MV_CUT;
                end else if (cur_reg == NIL) begin
                    fsm_next = S_MV_PUSH;
                end else begin
                    ctl.lnk_re = 1'b1;
                    lnk_raddr = EW'(cur_reg);
                    fsm_next = S_MV_HOP;
                end
            end
            S_MV_HOP: begin
                prev_next = cur_reg;
                cur_next = lnk_rdata;
                fsm_next = S_MV_WALK;
            end
            S_MV_CUT: begin
                if (prev_reg == NIL) begin
                    head_next[mv_s_reg] = lnk_rdata;
                end else begin
                    ctl.lnk_we = 1'b1;
                    lnk_waddr = EW'(prev_reg);
                    lnk_wdata = lnk_rdata;
                end
                if (tail_reg[mv_s_reg] == PW'(mv_e_reg)) begin
                    tail_next[mv_s_reg] = prev_reg;
                end
                fsm_next = S_MV_PUSH;
            end
            S_MV_PUSH: begin
                ctl.lnk_we = 1'b1;
                lnk_waddr = mv_e_reg;
                lnk_wdata = NIL;
                ctl.rec_we = 1'b1;
                rec_waddr = mv_e_reg;
                wr_rec = rec_reg;
                wr_rec.state = mv_ns_reg;
                if (head_reg[mv_ns_reg] == NIL) begin
                    head_next[mv_ns_reg] = PW'(mv_e_reg);
                    tail_next[mv_ns_reg] = PW'(mv_e_reg);
                    fsm_next = mv_ret_reg;
                end else begin
                    fsm_next = S_MV_LINK;
                end
            end
            S_MV_LINK: begin
                ctl.lnk_we = 1'b1;
                lnk_waddr = EW'(tail_reg[mv_ns_reg]);
                lnk_wdata = PW'(mv_e_reg);
                tail_next[mv_ns_reg] = PW'(mv_e_reg);
                fsm_next = mv_ret_reg;
            end
            S_FINISH: begin
                if (done_ready) begin
                    fsm_next = S_IDLE;
                end
            end
            default: begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    `PSLE_ASSERT(a_free_list_ends, (fsm_reg == S_IDLE) |-> ((head_reg[PS_UNUSED] == NIL) == (tail_reg[PS_UNUSED] == NIL)), "free list head and tail disagree")
    `PSLE_ASSERT(a_run_list_ends, (fsm_reg == S_IDLE) |-> ((head_reg[PS_RUNNABLE] == NIL) == (tail_reg[PS_RUNNABLE] == NIL)), "runnable list head and tail disagree")
    `PSLE_ASSERT_NEVER(a_stray_wake, (fsm_reg == S_FINISH) && (res_reg.woken_count != 7'd0) && (req_reg.action != ACT_WAKE) && (req_reg.action != ACT_EXIT) && (req_reg.action != ACT_KILL), "entries woken by an action that wakes none")
    `PSLE_ASSERT(a_empty_result, (fsm_reg == S_FINISH) && (res_reg.status == STS_EMPTY) |-> (res_reg.slot_out == 6'd0) && (res_reg.pid_out == 32'd0), "empty list result carries an entry")

endmodule
`default_nettype wire

// ----- tb/sv/process_state_list_engine_checker.sv -----
// Checker for the process state list engine: predicts every result and compares it.
`timescale 1ns / 100ps
module process_state_list_engine_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic [5:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [87:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,
    output int               errors,
    output int               pending
);
    import psle_pkg::*;

    localparam int N = 64;
    localparam int NIL = N;

    pstate_t     ent_state [N];
    int          ent_next  [N];
    int          head      [NSTATES];
    int          tail      [NSTATES];
    logic [31:0] ent_pid   [N];
    int          ent_parent[N];
    logic [31:0] ent_chan  [N];
    logic        ent_killed[N];
    logic [31:0] pid_counter;
    logic [5:0]  adopter_slot;
    res_t        result_fifo[$];

    function automatic void reset_model();
        for (int i = 0; i < N; i++) begin
            ent_state[i] = PS_UNUSED;
            ent_next[i] = i + 1;
            ent_pid[i] = '0;
            ent_parent[i] = NIL;
            ent_chan[i] = '0;
            ent_killed[i] = 1'b0;
        end
        for (int i = 0; i < NSTATES; i++) begin
            head[i] = NIL;
            tail[i] = NIL;
        end
        head[PS_UNUSED] = 0;
        tail[PS_UNUSED] = N - 1;
        pid_counter = 32'd1;
        adopter_slot = '0;
        result_fifo.delete();
    endfunction

    function automatic void push_tail(int s, int e);
        ent_next[e] = NIL;
        if (head[s] == NIL) begin
            head[s] = e;
        end else begin
            ent_next[tail[s]] = e;
        end
        tail[s] = e;
    endfunction

    function automatic void unlink(int s, int prev, int e);
        int nx;
        nx = ent_next[e];
        if (prev == NIL) head[s] = nx;
        else ent_next[prev] = nx;
        if (tail[s] == e) tail[s] = prev;
        ent_next[e] = NIL;
    endfunction

    function automatic void relist(int e, pstate_t ns);
        int s, cur, prev, n;
        s = ent_state[e];
        cur = head[s];
        prev = NIL;
        n = 0;
        while (cur < N && n < N) begin
            if (cur == e) begin
                unlink(s, prev, e);
                break;
            end
            prev = cur;
            cur = ent_next[cur];
            n++;
        end
        ent_state[e] = ns;
        push_tail(ns, e);
    endfunction

    function automatic int wake_sleepers(logic [31:0] tok);
        int cur, prev, n, woken, nx;
        cur = head[PS_SLEEPING];
        prev = NIL;
        n = 0;
        woken = 0;
        while (cur < N && n < N) begin
            nx = ent_next[cur];
            if (ent_chan[cur] == tok) begin
                unlink(PS_SLEEPING, prev, cur);
                ent_state[cur] = PS_RUNNABLE;
                ent_chan[cur] = '0;
                push_tail(PS_RUNNABLE, cur);
                woken++;
            end else begin
                prev = cur;
            end
            cur = nx;
            n++;
        end
        return woken;
    endfunction

    function automatic res_t run_action(req_t rq);
        res_t r;
        int e, slot, woken, found;
        pstate_t st;
        logic zombie_passed, kids;
        r = '0;
        r.status = STS_OK;
        slot = rq.slot;
        st = ent_state[slot];
        woken = 0;
        case (rq.action)
            ACT_ALLOC: begin
                e = head[PS_UNUSED];
                if (e >= N) begin
                    r.status = STS_EMPTY;
                end else begin
                    relist(e, PS_EMBRYO);
                    ent_pid[e] = pid_counter;
                    pid_counter = pid_counter + 32'd1;
                    ent_parent[e] = NIL;
                    ent_killed[e] = 1'b0;
                    ent_chan[e] = '0;
                    r.slot_out = e[5:0];
                    r.pid_out = ent_pid[e];
                end
            end
            ACT_START: begin
                if (st != PS_EMBRYO) begin
                    r.status = STS_WRONG_STATE;
                end else begin
                    ent_parent[slot] = rq.has_parent ? int'(rq.parent_slot) : NIL;
                    relist(slot, PS_RUNNABLE);
                end
            end
            ACT_FREE: begin
                if (st != PS_EMBRYO) begin
                    r.status = STS_WRONG_STATE;
                end else begin
                    ent_parent[slot] = NIL;
                    ent_killed[slot] = 1'b0;
                    ent_chan[slot] = '0;
                    relist(slot, PS_UNUSED);
                end
            end
            ACT_SCHED: begin
                e = head[PS_RUNNABLE];
                if (e >= N) begin
                    r.status = STS_EMPTY;
                end else begin
                    relist(e, PS_RUNNING);
                    r.slot_out = e[5:0];
                    r.pid_out = ent_pid[e];
                end
            end
            ACT_YIELD: begin
                if (st != PS_RUNNING) r.status = STS_WRONG_STATE;
                else relist(slot, PS_RUNNABLE);
            end
            ACT_SLEEP: begin
                if (st != PS_RUNNING) begin
                    r.status = STS_WRONG_STATE;
                end else begin
                    ent_chan[slot] = rq.chan;
                    relist(slot, PS_SLEEPING);
                end
            end
            ACT_WAKE: woken = wake_sleepers(rq.chan);
            ACT_EXIT: begin
                if (st != PS_RUNNING || slot == int'(adopter_slot)) begin
                    r.status = STS_WRONG_STATE;
                end else begin
                    zombie_passed = 1'b0;
                    if (ent_parent[slot] < N)
                        woken += wake_sleepers(32'(ent_parent[slot]));
                    for (int i = 0; i < N; i++) begin
                        if (ent_parent[i] == slot) begin
                            ent_parent[i] = adopter_slot;
                            if (ent_state[i] == PS_ZOMBIE) zombie_passed = 1'b1;
                        end
                    end
                    if (zombie_passed) woken += wake_sleepers(32'(adopter_slot));
                    relist(slot, PS_ZOMBIE);
                end
            end
            ACT_WAIT: begin
                if (st != PS_RUNNING) begin
                    r.status = STS_WRONG_STATE;
                end else begin
                    kids = 1'b0;
                    found = NIL;
                    for (int s = 0; s < NSTATES && found == NIL; s++) begin
                        int n;
                        e = head[s];
                        n = 0;
                        while (e < N && n < N) begin
                            if (ent_parent[e] == slot) begin
                                kids = 1'b1;
                                if (ent_state[e] == PS_ZOMBIE) begin
                                    found = e;
                                    break;
                                end
                            end
                            e = ent_next[e];
                            n++;
                        end
                    end
                    if (found < N) begin
                        r.slot_out = found[5:0];
                        r.pid_out = ent_pid[found];
                        ent_pid[found] = '0;
                        ent_parent[found] = NIL;
                        ent_killed[found] = 1'b0;
                        ent_chan[found] = '0;
                        relist(found, PS_UNUSED);
                    end else if (!kids) begin
                        r.status = STS_NO_CHILDREN;
                    end else begin
                        r.status = ent_killed[slot] ? STS_CALLER_KILLED : STS_CHILDREN_ALIVE;
                    end
                end
            end
            ACT_KILL: begin
                r.status = STS_NOT_FOUND;
                for (int i = 0; i < N; i++) begin
                    if (ent_state[i] inside {PS_EMBRYO, PS_SLEEPING, PS_RUNNABLE, PS_RUNNING}
                            && ent_pid[i] == rq.target_pid) begin
                        ent_killed[i] = 1'b1;
                        if (ent_state[i] == PS_SLEEPING) begin
                            ent_chan[i] = '0;
                            relist(i, PS_RUNNABLE);
                            woken = 1;
                        end
                        r.status = STS_OK;
                        break;
                    end
                end
            end
            default: r.status = STS_WRONG_STATE;
        endcase
        r.woken_count = woken[6:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        res_t got, want;
        if (!aresetn) begin
            reset_model();
            errors = 0;
            pending = 0;
        end else begin
            if (cfg_wen) adopter_slot = cfg_wdata;
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata);
                if (result_fifo.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = result_fifo.pop_front();
                    if (got.status != want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        errors++;
                    end
                    if (got.slot_out != want.slot_out) begin
                        $display("%0t: slot_out expected %0d actual %0d",
                                 $time, want.slot_out, got.slot_out);
                        errors++;
                    end
                    if (got.pid_out != want.pid_out) begin
                        $display("%0t: pid_out expected %0d actual %0d",
                                 $time, want.pid_out, got.pid_out);
                        errors++;
                    end
                    if (got.woken_count != want.woken_count) begin
                        $display("%0t: woken_count expected %0d actual %0d",
                                 $time, want.woken_count, got.woken_count);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) result_fifo.push_back(run_action(req_t'(s_tdata[80:0])));
            pending = result_fifo.size();
        end
    end
endmodule

// ----- tb/sv/process_state_list_engine_tb.sv -----
// Testbench top for the process state list engine: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module process_state_list_engine_tb;
    import psle_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [5:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    int          errors;
    int          pending;
    logic        steady = 1'b0;
    logic        hold_req = 1'b0;

    process_state_list_engine dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    process_state_list_engine_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #50ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 15);
        end
    end

    task automatic send_action(logic [3:0] act, logic [5:0] slot, logic hp,
                               logic [5:0] ps, logic [31:0] chan, logic [31:0] tpid);
        req_t rq;
        rq = {tpid, chan, ps, hp, slot, act};
        while (!steady && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, rq};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random();
        int r;
        logic [3:0] act;
        r = $urandom_range(99);
        if (r < 12) act = ACT_ALLOC;
        else if (r < 22) act = ACT_START;
        else if (r < 26) act = ACT_FREE;
        else if (r < 40) act = ACT_SCHED;
        else if (r < 49) act = ACT_YIELD;
        else if (r < 59) act = ACT_SLEEP;
        else if (r < 69) act = ACT_WAKE;
        else if (r < 79) act = ACT_EXIT;
        else if (r < 90) act = ACT_WAIT;
        else if (r < 97) act = ACT_KILL;
        else act = 4'($urandom_range(10, 15));
        send_action(act,
                    ($urandom_range(99) < 85) ? 6'($urandom_range(15)) : 6'($urandom),
                    $urandom_range(99) < 80,
                    ($urandom_range(99) < 80) ? 6'($urandom_range(15)) : 6'($urandom),
                    ($urandom_range(99) < 70) ? 32'($urandom_range(15)) : $urandom,
                    ($urandom_range(99) < 70) ? 32'($urandom_range(250)) : $urandom);
    endtask

    task automatic settle_and_write(logic [5:0] v);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    initial begin
        logic [5:0] settings [4];
        settings = '{6'd63, 6'($urandom_range(1, 62)), 6'd1, 6'd0};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        settle_and_write(6'd0);

        send_action(ACT_WAIT, 6'd0, 1'b0, 6'd0, 32'd0, 32'd0);
        send_action(ACT_SCHED, 6'd0, 1'b0, 6'd0, 32'd0, 32'd0);
        send_action(ACT_ALLOC, 6'd0, 1'b0, 6'd0, 32'd0, 32'd0);
        send_action(ACT_ALLOC, 6'd0, 1'b0, 6'd0, 32'd0, 32'd0);
        send_action(ACT_ALLOC, 6'd0, 1'b0, 6'd0, 32'd0, 32'd0);
        send_action(ACT_ALLOC, 6'd0, 1'b0, 6'd0, 32'd0, 32'd0);
        send_action(ACT_START, 6'd0, 1'b0, 6'd63, 32'd0, 32'd0);
        send_action(ACT_START, 6'd1, 1'b1, 6'd0, 32'd0, 32'd0);
        send_action(ACT_START, 6'd2, 1'b1, 6'd1, 32'd0, 32'd0);
        send_action(ACT_FREE, 6'd3, 1'b0, 6'd0, 32'd0, 32'd0);
        send_action(ACT_SCHED, 6'd0, 1'b0, 6'd0, 32'd0, 32'd0);
        send_action(ACT_SCHED, 6'd0, 1'b0, 6'd0, 32'd0, 32'd0);
        send_action(ACT_SCHED, 6'd0, 1'b0, 6'd0, 32'd0, 32'd0);
        send_action(ACT_WAIT, 6'd0, 1'b0, 6'd0, 32'd0, 32'd0);
        send_action(ACT_SLEEP, 6'd1, 1'b0, 6'd0, 32'hFFFF_FFFF, 32'd0);
        send_action(ACT_KILL, 6'd0, 1'b0, 6'd0, 32'd0, 32'd2);
        send_action(ACT_KILL, 6'd0, 1'b0, 6'd0, 32'd0, 32'hFFFF_FFFF);
        send_action(ACT_SCHED, 6'd0, 1'b0, 6'd0, 32'd0, 32'd0);
        send_action(ACT_EXIT, 6'd2, 1'b0, 6'd0, 32'd0, 32'd0);
        send_action(ACT_WAIT, 6'd1, 1'b0, 6'd0, 32'd0, 32'd0);
        send_action(ACT_EXIT, 6'd1, 1'b0, 6'd0, 32'd0, 32'd0);
        send_action(ACT_EXIT, 6'd0, 1'b0, 6'd0, 32'd0, 32'd0);
        send_action(ACT_WAKE, 6'd63, 1'b1, 6'd63, 32'hFFFF_FFFF, 32'd0);
        send_action(4'd15, 6'd63, 1'b1, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < 360; k++) begin
                steady = (ph == 2 && k >= 100 && k < 300);
                if (ph == 1 && k == 150) hold_req = 1'b1;
                send_random();
            end
            steady = 1'b0;
            settle_and_write(settings[ph]);
        end

        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
